// ===== rtl/core/sset_pkg.sv =====
// ----------------------------------------------------------------------------
// Size-sorted entry table package
// Shared constants, field widths and the control/status bundles that join the
// sequencer to the table datapath.
// ----------------------------------------------------------------------------
package sset_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int CMD_W    = 3;
   localparam int UID_W    = 16;
   localparam int SIZE_W   = 31;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_COUNT_M1,
      PTR_ONES,
      PTR_ZERO,
      PTR_INC,
      PTR_DEC,
      PTR_IDX
   } ptr_op_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_SHIFT_UP,
      WR_NEW,
      WR_SHIFT_DOWN
   } wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } cnt_op_type;

   typedef enum logic [1:0] {
      POS_HOLD,
      POS_PTR,
      POS_PTR_P1
   } pos_op_type;

   typedef struct packed {
      logic                latch;
      ptr_op_type          ptr_op;
      wr_op_type           wr_op;
      cnt_op_type          cnt_op;
      pos_op_type          pos_op;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                capture;
      logic                out_load;
   } sset_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             full;
      logic             empty;
      logic             idx_over;
      logic             size_gt;
      logic             uid_hit;
      logic             at_last;
      logic             ptr_zero;
      logic             out_free;
   } sset_sts_type;

endpackage

// ===== rtl/core/size_sorted_entry_table_unit.sv =====
// ----------------------------------------------------------------------------
// Size-sorted entry table
// Table of (id, size) entries kept in descending size order, with insert,
// remove, find, read and clear requests and one response per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. The entry memory, with one write port and
// one registered read port, is walked one slot per cycle (from the head for
// find and remove, from the tail for insert, with the gap closed or opened in
// the same pass). A new request is taken as soon as the previous response is
// in the output register, even if that response is still waiting to be taken.
module size_sorted_entry_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // item_uid[15:0], item_size[46:16], entry_index[50:47]
   input  logic [2:0]  req_tuser,   // cmd[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // found_index[3:0], entry_count[8:4], read_uid[24:9],
                                    // read_size[55:25]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import sset_pkg::*;

   sset_cmd_type         ctl;
   sset_sts_type         sts;
   logic [POS_W-1:0]     found_index;
   logic [COUNT_W-1:0]   entry_count;
   logic [UID_W-1:0]     read_uid;
   logic [SIZE_W-1:0]    read_size;

   sset_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .ctl       (ctl)
   );

   sset_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_tuser),
      .req_item_uid    (req_tdata[15:0]),
      .req_item_size   (req_tdata[46:16]),
      .req_entry_index (req_tdata[50:47]),
      .ctl             (ctl),
      .sts             (sts),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (rsp_tuser),
      .rsp_found_index (found_index),
      .rsp_entry_count (entry_count),
      .rsp_read_uid    (read_uid),
      .rsp_read_size   (read_size)
   );

   assign rsp_tdata = {read_size, read_uid, entry_count, found_index};

endmodule

// ===== rtl/core/sset_dpath.sv =====
// ----------------------------------------------------------------------------
// Size-sorted entry table datapath
// Entry memory with registered read, scan pointer, entry count, request
// holding registers, result registers and the response output register.
// ----------------------------------------------------------------------------
module sset_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [sset_pkg::CMD_W-1:0]      req_cmd,
   input  logic [sset_pkg::UID_W-1:0]      req_item_uid,
   input  logic [sset_pkg::SIZE_W-1:0]     req_item_size,
   input  logic [sset_pkg::INDEX_W-1:0]    req_entry_index,
   input  sset_pkg::sset_cmd_type          ctl,
   output sset_pkg::sset_sts_type          sts,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [sset_pkg::STATUS_W-1:0]   rsp_status,
   output logic [sset_pkg::POS_W-1:0]      rsp_found_index,
   output logic [sset_pkg::COUNT_W-1:0]    rsp_entry_count,
   output logic [sset_pkg::UID_W-1:0]      rsp_read_uid,
   output logic [sset_pkg::SIZE_W-1:0]     rsp_read_size
);
   import sset_pkg::*;

   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   logic [UID_W-1:0]    mem_uid  [CAPACITY];
   logic [SIZE_W-1:0]   mem_size [CAPACITY];

   logic [CMD_W-1:0]    cmd_ff;
   logic [UID_W-1:0]    uid_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [INDEX_W-1:0]  idx_ff;

   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [UID_W-1:0]    rd_uid_ff;
   logic [SIZE_W-1:0]   rd_size_ff;

   logic [STATUS_W-1:0] res_status_ff;
   logic [IDX_W-1:0]    pos_ff;
   logic [UID_W-1:0]    res_uid_ff;
   logic [SIZE_W-1:0]   res_size_ff;

   logic                out_valid_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [POS_W-1:0]    out_pos_ff;
   logic [COUNT_W-1:0]  out_count_ff;
   logic [UID_W-1:0]    out_uid_ff;
   logic [SIZE_W-1:0]   out_size_ff;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [UID_W-1:0]    wr_uid;
   logic [SIZE_W-1:0]   wr_size;
   logic [IDX_W-1:0]    ptr_p1;
   logic [CMP_W-1:0]    idx_ext, cnt_ext;

   assign ptr_p1  = ptr_ff + 1'b1;
   assign idx_ext = CMP_W'(idx_ff);
   assign cnt_ext = CMP_W'(count_ff);

   always_comb begin
      case (ctl.ptr_op)
         PTR_COUNT_M1: ptr_in = IDX_W'(count_ff - 1'b1);
         PTR_ONES:     ptr_in = '1;
         PTR_ZERO:     ptr_in = '0;
         PTR_INC:      ptr_in = ptr_p1;
         PTR_DEC:      ptr_in = ptr_ff - 1'b1;
         PTR_IDX:      ptr_in = IDX_W'(idx_ff);
         default:      ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      case (ctl.cnt_op)
         CNT_INC:   count_in = count_ff + 1'b1;
         CNT_DEC:   count_in = count_ff - 1'b1;
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   // insert moves entries up toward the tail, remove closes the gap downward
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = ptr_p1;
      wr_uid  = rd_uid_ff;
      wr_size = rd_size_ff;
      case (ctl.wr_op)
         WR_SHIFT_UP: begin
         end
         WR_NEW: begin
            wr_uid  = uid_ff;
            wr_size = size_ff;
         end
         WR_SHIFT_DOWN: begin
            wr_addr = ptr_ff - 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_uid[wr_addr]  <= wr_uid;
         mem_size[wr_addr] <= wr_size;
      end
      rd_uid_ff  <= mem_uid[ptr_in];
      rd_size_ff <= mem_size[ptr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (ctl.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (ctl.latch) begin
         cmd_ff        <= req_cmd;
         uid_ff        <= req_item_uid;
         size_ff       <= req_item_size;
         idx_ff        <= req_entry_index;
         res_status_ff <= STATUS_OK;
         pos_ff        <= '0;
         res_uid_ff    <= '0;
         res_size_ff   <= '0;
      end else begin
         if (ctl.set_status) begin
            res_status_ff <= ctl.status;
         end
         case (ctl.pos_op)
            POS_PTR:    pos_ff <= ptr_ff;
            POS_PTR_P1: pos_ff <= ptr_p1;
            default:    pos_ff <= pos_ff;
         endcase
         if (ctl.capture) begin
            res_uid_ff  <= rd_uid_ff;
            res_size_ff <= rd_size_ff;
         end
      end
      if (ctl.out_load) begin
         out_status_ff <= res_status_ff;
         out_pos_ff    <= POS_W'(pos_ff);
         out_count_ff  <= COUNT_W'(count_ff);
         out_uid_ff    <= res_uid_ff;
         out_size_ff   <= res_size_ff;
      end
   end

   always_comb begin
      sts.cmd      = cmd_ff;
      sts.full     = (count_ff == CNT_W'(CAPACITY));
      sts.empty    = (count_ff == '0);
      sts.idx_over = (idx_ext >= cnt_ext);
      sts.size_gt  = (size_ff > rd_size_ff);
      sts.uid_hit  = (uid_ff == rd_uid_ff);
      sts.at_last  = ((CNT_W'(ptr_ff) + 1'b1) == count_ff);
      sts.ptr_zero = (ptr_ff == '0);
      sts.out_free = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_found_index = out_pos_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_read_uid    = out_uid_ff;
   assign rsp_read_size   = out_size_ff;

endmodule

// ===== rtl/core/sset_ctrl.sv =====
// ----------------------------------------------------------------------------
// Size-sorted entry table sequencer
// Decodes each request and steps the datapath through its scan, shift and
// result phases.
// ----------------------------------------------------------------------------
module sset_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sset_pkg::sset_sts_type sts,
   output sset_pkg::sset_cmd_type ctl
);
   import sset_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_INS_SHIFT,
      S_INS_PLACE,
      S_SCAN,
      S_REM_SHIFT,
      S_READ,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            case (sts.cmd)
               CMD_INSERT: begin
                  if (sts.full) begin
                     ctl.set_status = 1'b1;
                     ctl.status     = STATUS_FULL;
                  end else if (sts.empty) begin
                     ctl.ptr_op = PTR_ONES;   // place lands on slot zero
                     state_in   = S_INS_PLACE;
                  end else begin
                     ctl.ptr_op = PTR_COUNT_M1;
                     state_in   = S_INS_SHIFT;
                  end
               end
               CMD_REMOVE, CMD_FIND: begin
                  if (sts.empty) begin
                     ctl.set_status = 1'b1;
                     ctl.status     = STATUS_EMPTY;
                  end else begin
                     ctl.ptr_op = PTR_ZERO;
                     state_in   = S_SCAN;
                  end
               end
               CMD_READ: begin
                  if (sts.empty) begin
                     ctl.set_status = 1'b1;
                     ctl.status     = STATUS_EMPTY;
                  end else if (sts.idx_over) begin
                     ctl.set_status = 1'b1;
                     ctl.status     = STATUS_MISSING;
                  end else begin
                     ctl.ptr_op = PTR_IDX;
                     state_in   = S_READ;
                  end
               end
               CMD_CLEAR: begin
                  ctl.cnt_op = CNT_CLEAR;
               end
               default: begin
               end
            endcase
         end
         // walk from the tail; smaller entries move up one slot
         S_INS_SHIFT: begin
            if (sts.size_gt) begin
               ctl.wr_op  = WR_SHIFT_UP;
               ctl.ptr_op = PTR_DEC;
               if (sts.ptr_zero) begin
                  state_in = S_INS_PLACE;
               end
            end else begin
               state_in = S_INS_PLACE;
            end
         end
         S_INS_PLACE: begin
            ctl.wr_op  = WR_NEW;
            ctl.pos_op = POS_PTR_P1;
            ctl.cnt_op = CNT_INC;
            state_in   = S_DONE;
         end
         S_SCAN: begin
            if (sts.uid_hit) begin
               ctl.pos_op = POS_PTR;
               if (sts.cmd == CMD_FIND) begin
                  state_in = S_DONE;
               end else if (sts.at_last) begin
                  ctl.cnt_op = CNT_DEC;
                  state_in   = S_DONE;
               end else begin
                  ctl.ptr_op = PTR_INC;
                  state_in   = S_REM_SHIFT;
               end
            end else if (sts.at_last) begin
               ctl.set_status = 1'b1;
               ctl.status     = STATUS_MISSING;
               state_in       = S_DONE;
            end else begin
               ctl.ptr_op = PTR_INC;
            end
         end
         S_REM_SHIFT: begin
            ctl.wr_op = WR_SHIFT_DOWN;
            if (sts.at_last) begin
               ctl.cnt_op = CNT_DEC;
               state_in   = S_DONE;
            end else begin
               ctl.ptr_op = PTR_INC;
            end
         end
         S_READ: begin
            ctl.capture = 1'b1;
            ctl.pos_op  = POS_PTR;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Size-sorted entry table testbench
// Drives insert, remove, find, read and clear requests into the table through
// the request stream, with random bursts and response stalls. Each response is
// checked field by field against a directed row or a behavioral copy of the table.
// ----------------------------------------------------------------------------
module testbench;
   import sset_pkg::*;

   localparam int RANDOM_REQUESTS = 1300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 2 * (CAPACITY + 4);
   localparam int DIRECTED_ROWS   = 17;

   // commands 5..7 are not decoded by the table
   localparam logic [CMD_W-1:0]  CMD_SPARE = 3'd7;
   localparam logic [UID_W-1:0]  UID_MAX   = '1;
   localparam logic [SIZE_W-1:0] SIZE_MAX  = '1;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [UID_W-1:0]   uid;
      logic [SIZE_W-1:0]  size;
      logic [INDEX_W-1:0] index;
   } table_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  count;
      logic [UID_W-1:0]    rd_uid;
      logic [SIZE_W-1:0]   rd_size;
   } table_result_type;

   // one directed row; reps > 1 repeats an insert with the id stepped each time
   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [UID_W-1:0]    uid;
      logic [SIZE_W-1:0]   size;
      logic [INDEX_W-1:0]  index;
      logic [4:0]          reps;
      logic                typed;
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  count;
      logic [UID_W-1:0]    rd_uid;
      logic [SIZE_W-1:0]   rd_size;
   } directed_row_type;

   typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED, PHASE_NOISE} traffic_phase_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;   // item_uid, item_size, entry_index, zero fill
   logic [2:0]  req_tuser  = '0;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // found_index, entry_count, read_uid, read_size
   logic [1:0]  rsp_tuser;         // status

   table_result_type pending_results[$];
   bit               mismatch_seen = 1'b0;

   logic [UID_W-1:0]  shadow_uid  [CAPACITY];
   logic [SIZE_W-1:0] shadow_size [CAPACITY];
   int                shadow_fill;

   directed_row_type directed_rows [DIRECTED_ROWS];

   size_sorted_entry_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int first_uid_slot(input logic [UID_W-1:0] uid);
      int i;
      for (i = 0; i < shadow_fill; i++) begin
         if (shadow_uid[i] == uid) return i;
      end
      return -1;
   endfunction

   // applies one request to the shadow table and returns the response it yields
   function automatic table_result_type apply_table_request(input table_req_type rq);
      table_result_type r;
      int               slot;
      int               i;
      r = '0;
      r.status = STATUS_OK;
      case (rq.cmd)
         CMD_INSERT: begin
            if (shadow_fill >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               // equal sizes keep arrival order: stop only at a strictly smaller one
               slot = 0;
               while (slot < shadow_fill && rq.size <= shadow_size[slot]) slot++;
               for (i = shadow_fill; i > slot; i--) begin
                  shadow_uid[i]  = shadow_uid[i-1];
                  shadow_size[i] = shadow_size[i-1];
               end
               shadow_uid[slot]  = rq.uid;
               shadow_size[slot] = rq.size;
               shadow_fill++;
               r.position = POS_W'(slot);
            end
         end
         CMD_REMOVE: begin
            slot = first_uid_slot(rq.uid);
            if (shadow_fill == 0) begin
               r.status = STATUS_EMPTY;
            end else if (slot < 0) begin
               r.status = STATUS_MISSING;
            end else begin
               for (i = slot; i + 1 < shadow_fill; i++) begin
                  shadow_uid[i]  = shadow_uid[i+1];
                  shadow_size[i] = shadow_size[i+1];
               end
               shadow_fill--;
               shadow_uid[shadow_fill]  = '0;
               shadow_size[shadow_fill] = '0;
               r.position = POS_W'(slot);
            end
         end
         CMD_FIND: begin
            slot = first_uid_slot(rq.uid);
            if (shadow_fill == 0) r.status = STATUS_EMPTY;
            else if (slot < 0) r.status = STATUS_MISSING;
            else r.position = POS_W'(slot);
         end
         CMD_READ: begin
            if (shadow_fill == 0) begin
               r.status = STATUS_EMPTY;
            end else if (int'(rq.index) >= shadow_fill) begin
               r.status = STATUS_MISSING;
            end else begin
               r.position = rq.index;
               r.rd_uid   = shadow_uid[rq.index];
               r.rd_size  = shadow_size[rq.index];
            end
         end
         CMD_CLEAR: begin
            for (i = 0; i < CAPACITY; i++) begin
               shadow_uid[i]  = '0;
               shadow_size[i] = '0;
            end
            shadow_fill = 0;
         end
         default: ;
      endcase
      r.count = COUNT_W'(shadow_fill);
      return r;
   endfunction

   function automatic logic [UID_W-1:0] pick_uid(input bit prefer_present);
      if (prefer_present && shadow_fill > 0 && $urandom_range(9) < 7)
         return shadow_uid[$urandom_range(shadow_fill - 1)];
      // a small id pool makes duplicates and hits likely
      if ($urandom_range(1) == 0) return UID_W'($urandom_range(15));
      return UID_W'($urandom());
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 35) return SIZE_W'($urandom_range(7));
      if (roll < 80) return SIZE_W'($urandom());
      if (roll < 90) return SIZE_MAX;
      return '0;
   endfunction

   function automatic table_req_type make_request(input traffic_phase_type phase);
      table_req_type rq;
      int            roll;
      roll = $urandom_range(99);
      rq.size  = pick_size();
      rq.index = INDEX_W'($urandom_range(15));
      if (shadow_fill > 0 && $urandom_range(1) == 0)
         rq.index = INDEX_W'($urandom_range(shadow_fill - 1));
      case (phase)
         PHASE_FILL:
            rq.cmd = (roll < 70) ? CMD_INSERT : (roll < 80) ? CMD_FIND :
                     (roll < 90) ? CMD_READ : (roll < 99) ? CMD_REMOVE : CMD_CLEAR;
         PHASE_DRAIN:
            rq.cmd = (roll < 15) ? CMD_INSERT : (roll < 60) ? CMD_REMOVE :
                     (roll < 75) ? CMD_FIND : (roll < 99) ? CMD_READ : CMD_CLEAR;
         PHASE_MIXED:
            rq.cmd = (roll < 35) ? CMD_INSERT : (roll < 60) ? CMD_REMOVE :
                     (roll < 75) ? CMD_FIND : (roll < 97) ? CMD_READ : CMD_CLEAR;
         default:
            rq.cmd = CMD_W'($urandom_range(7));
      endcase
      rq.uid = pick_uid(rq.cmd != CMD_INSERT && phase != PHASE_NOISE);
      if (phase == PHASE_NOISE) begin
         rq.size  = SIZE_W'($urandom());
         rq.index = INDEX_W'($urandom());
      end
      return rq;
   endfunction

   // drives one request and returns once it is accepted
   task automatic issue_request(input table_req_type rq, input logic typed,
                                input table_result_type typed_result);
      table_result_type predicted;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= rq.cmd;
      req_tdata  <= {{(56 - UID_W - SIZE_W - INDEX_W){1'b0}}, rq.index, rq.size, rq.uid};
      do @(posedge clock); while (!req_tready);
      predicted = apply_table_request(rq);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   task automatic sender_gap(input int cycles);
      repeat (cycles) @(negedge clock) req_tvalid <= 1'b0;
   endtask

   task automatic hold_until_drained();
      sender_gap(1);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // response side stalls on its own schedule
   initial begin : response_stalls
      int style;
      int span;
      int low_left;
      forever begin
         style = $urandom_range(3);
         span  = $urandom_range(20, 100);
         low_left = 0;
         repeat (span) begin
            @(negedge clock);
            case (style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(1) == 0);
               2: begin
                  if (low_left == 0 && $urandom_range(9) == 0) low_left = $urandom_range(5, 30);
                  rsp_tready <= (low_left == 0);
                  if (low_left > 0) low_left--;
               end
               default: rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   always @(posedge clock) begin : response_check
      table_result_type got;
      table_result_type want;
      if (rsp_tvalid && rsp_tready) begin
         got.status   = rsp_tuser;
         got.position = rsp_tdata[3:0];
         got.count    = rsp_tdata[8:4];
         got.rd_uid   = rsp_tdata[24:9];
         got.rd_size  = rsp_tdata[55:25];
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_seen = 1'b1;
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               mismatch_seen = 1'b1;
            end
            if (got.position !== want.position) begin
               $error("found_index: expected %0d, got %0d", want.position, got.position);
               mismatch_seen = 1'b1;
            end
            if (got.count !== want.count) begin
               $error("entry_count: expected %0d, got %0d", want.count, got.count);
               mismatch_seen = 1'b1;
            end
            if (got.rd_uid !== want.rd_uid) begin
               $error("read_uid: expected 0x%0h, got 0x%0h", want.rd_uid, got.rd_uid);
               mismatch_seen = 1'b1;
            end
            if (got.rd_size !== want.rd_size) begin
               $error("read_size: expected 0x%0h, got 0x%0h", want.rd_size, got.rd_size);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      table_req_type     rq;
      table_result_type  typed_result;
      traffic_phase_type phase;
      int                row;
      int                rep;
      int                roll;
      int                phase_len;
      int                burst_left;
      int                max_gap;
      int                requests_sent;
      int                k;

      for (k = 0; k < CAPACITY; k++) begin
         shadow_uid[k]  = '0;
         shadow_size[k] = '0;
      end
      shadow_fill = 0;

      //  cmd         uid        size          idx  reps typed status          pos cnt uid  size
      directed_rows = '{
         '{CMD_READ,   16'h0,    31'h0,        4'd0,  5'd1, 1'b1, STATUS_EMPTY,   4'd0, 5'd0,
           16'h0, 31'h0},
         '{CMD_REMOVE, 16'h0,    31'h0,        4'd0,  5'd1, 1'b1, STATUS_EMPTY,   4'd0, 5'd0,
           16'h0, 31'h0},
         '{CMD_FIND,   UID_MAX,  31'h0,        4'd0,  5'd1, 1'b1, STATUS_EMPTY,   4'd0, 5'd0,
           16'h0, 31'h0},
         '{CMD_INSERT, UID_MAX,  SIZE_MAX,     4'd0,  5'd1, 1'b1, STATUS_OK,      4'd0, 5'd1,
           16'h0, 31'h0},
         '{CMD_INSERT, 16'h0,    31'h0,        4'd15, 5'd1, 1'b1, STATUS_OK,      4'd1, 5'd2,
           16'h0, 31'h0},
         // same size as the head: lands behind it
         '{CMD_INSERT, 16'h1234, SIZE_MAX,     4'd0,  5'd1, 1'b1, STATUS_OK,      4'd1, 5'd3,
           16'h0, 31'h0},
         // duplicate id
         '{CMD_INSERT, 16'h1234, 31'h5,        4'd0,  5'd1, 1'b0, STATUS_OK,      4'd0, 5'd0,
           16'h0, 31'h0},
         '{CMD_FIND,   16'h1234, 31'h0,        4'd0,  5'd1, 1'b0, STATUS_OK,      4'd0, 5'd0,
           16'h0, 31'h0},
         '{CMD_READ,   16'h0,    31'h0,        4'd15, 5'd1, 1'b1, STATUS_MISSING, 4'd0, 5'd4,
           16'h0, 31'h0},
         '{CMD_READ,   16'h0,    31'h0,        4'd0,  5'd1, 1'b1, STATUS_OK,      4'd0, 5'd4,
           UID_MAX, SIZE_MAX},
         '{CMD_REMOVE, 16'hABCD, 31'h0,        4'd0,  5'd1, 1'b1, STATUS_MISSING, 4'd0, 5'd4,
           16'h0, 31'h0},
         '{CMD_REMOVE, 16'h1234, 31'h0,        4'd0,  5'd1, 1'b0, STATUS_OK,      4'd0, 5'd0,
           16'h0, 31'h0},
         '{CMD_SPARE,  UID_MAX,  SIZE_MAX,     4'd15, 5'd1, 1'b1, STATUS_OK,      4'd0, 5'd3,
           16'h0, 31'h0},
         // fill to capacity with equal sizes
         '{CMD_INSERT, 16'h5500, 31'h2AAAAAAA, 4'd0,  5'd13, 1'b0, STATUS_OK,     4'd0, 5'd0,
           16'h0, 31'h0},
         '{CMD_INSERT, 16'h00FF, 31'h1,        4'd0,  5'd1, 1'b1, STATUS_FULL,    4'd0, 5'd16,
           16'h0, 31'h0},
         '{CMD_READ,   16'h0,    31'h0,        4'd15, 5'd1, 1'b0, STATUS_OK,      4'd0, 5'd0,
           16'h0, 31'h0},
         '{CMD_CLEAR,  UID_MAX,  SIZE_MAX,     4'd15, 5'd1, 1'b1, STATUS_OK,      4'd0, 5'd0,
           16'h0, 31'h0}
      };

      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         for (rep = 0; rep < directed_rows[row].reps; rep++) begin
            rq.cmd   = directed_rows[row].cmd;
            rq.uid   = directed_rows[row].uid + UID_W'(rep);
            rq.size  = directed_rows[row].size;
            rq.index = directed_rows[row].index;
            typed_result = '{directed_rows[row].status, directed_rows[row].position,
                             directed_rows[row].count, directed_rows[row].rd_uid,
                             directed_rows[row].rd_size};
            issue_request(rq, directed_rows[row].typed, typed_result);
            sender_gap($urandom_range(2));
         end
      end

      hold_until_drained();

      requests_sent = 0;
      burst_left    = 0;
      while (requests_sent < RANDOM_REQUESTS) begin
         roll  = $urandom_range(9);
         phase = (roll < 3) ? PHASE_FILL : (roll < 6) ? PHASE_DRAIN :
                 (roll < 9) ? PHASE_MIXED : PHASE_NOISE;
         phase_len = $urandom_range(10, 80);
         // zero max_gap gives back-to-back stretches
         max_gap = $urandom_range(2) * 4;
         if ($urandom_range(9) == 0) hold_until_drained();
         for (k = 0; k < phase_len && requests_sent < RANDOM_REQUESTS; k++) begin
            rq = make_request(phase);
            issue_request(rq, 1'b0, '0);
            if (rq.cmd <= CMD_CLEAR) requests_sent++;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
               sender_gap($urandom_range(max_gap));
            end else begin
               burst_left--;
            end
         end
      end

      sender_gap(1);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (!mismatch_seen && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
